/* hw/rtl/ioat_pkg.sv */
`default_nettype none

package ioat_pkg;

    localparam int CAPACITY      = 64;
    localparam int POSITION_BITS = 32;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHG_W   = 32;
    localparam int SUM_W   = 38;
    localparam int RECON_W = SUM_W + 2;
    localparam int ENTRY_W = POSITION_BITS + CHG_W;
    localparam int CFG_W   = 32;

    localparam logic CFG_ORIGINAL_LENGTH = 1'b0;
    localparam logic CFG_MODIFIED_LENGTH = 1'b1;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/ioat_ram.sv */
`default_nettype none

module ioat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ioat_ctrl.sv */
`default_nettype none

module ioat_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ioat_pkg::status_t status,
    output      ioat_pkg::cmd_t    cmd,
    output      logic              busy
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.empty ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/ioat_dp.sv */
`default_nettype none

module ioat_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ioat_pkg::cmd_t                    cmd,
    output      ioat_pkg::status_t                 status,
    input  wire logic                              op,
    input  wire logic [31:0]                       position,
    input  wire logic signed [ioat_pkg::CHG_W-1:0] size_change,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [ioat_pkg::CFG_W-1:0]        cfg_data,
    output      logic                              done,
    output      logic signed [ioat_pkg::SUM_W-1:0] offset_adjust,
    output      logic                              insert_ok,
    output      logic                              duplicate,
    output      logic                              table_full,
    output      logic                              reconcile_ok
);

    localparam int PB = ioat_pkg::POSITION_BITS;
    localparam int CW = ioat_pkg::CHG_W;
    localparam int SW = ioat_pkg::SUM_W;
    localparam int RW = ioat_pkg::RECON_W;
    localparam int NW = ioat_pkg::CNT_W;
    localparam int XW = ioat_pkg::IDX_W;

    logic                 op_reg;
    logic [PB-1:0]        pos_reg;
    logic [CW-1:0]        chg_reg;
    logic [XW-1:0]        idx_reg;
    logic                 pending_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 found_reg;
    logic [NW-1:0]        count_reg;
    logic signed [SW-1:0] total_reg;
    logic [ioat_pkg::CFG_W-1:0] orig_reg;
    logic [ioat_pkg::CFG_W-1:0] mod_reg;

    logic                 done_reg;
    logic signed [SW-1:0] offset_reg;
    logic                 ok_reg;
    logic                 dup_reg;
    logic                 full_reg;
    logic                 recon_reg;

    logic [ioat_pkg::ENTRY_W-1:0] rdata;
    logic [PB-1:0]                rd_pos;
    logic signed [CW-1:0]         rd_chg;
    logic                         is_full;
    logic                         do_write;
    logic signed [SW-1:0]         total_next;
    logic signed [RW-1:0]         recon_sum;

    ioat_ram #(
        .WIDTH(ioat_pkg::ENTRY_W),
        .DEPTH(ioat_pkg::CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (do_write),
        .waddr(count_reg[XW-1:0]),
        .wdata({pos_reg, chg_reg}),
        .re   (cmd.step),
        .raddr(idx_reg),
        .rdata(rdata)
    );

    assign rd_pos = rdata[ioat_pkg::ENTRY_W-1:CW];
    assign rd_chg = $signed(rdata[CW-1:0]);

    assign status.empty = (count_reg == '0);
    assign status.last  = ((NW'(idx_reg) + NW'(1)) == count_reg);

    assign is_full  = (count_reg == NW'(ioat_pkg::CAPACITY));
    assign do_write = cmd.finish && (op_reg == ioat_pkg::OP_INSERT) && !found_reg && !is_full;

    always_comb
    begin
        total_next = total_reg;
        if (do_write)
        begin
            total_next = total_reg + SW'($signed(chg_reg));
        end
    end

    assign recon_sum = RW'($signed({1'b0, orig_reg})) + RW'(total_next);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            pos_reg <= PB'(position);
            chg_reg <= size_change;
        end
        if (cmd.finish)
        begin
            offset_reg <= sum_reg;
            ok_reg     <= do_write;
            dup_reg    <= (op_reg == ioat_pkg::OP_INSERT) && found_reg;
            full_reg   <= (op_reg == ioat_pkg::OP_INSERT) && !found_reg && is_full;
            recon_reg  <= (recon_sum == RW'($signed({1'b0, mod_reg})));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            pending_reg <= 1'b0;
            sum_reg     <= '0;
            found_reg   <= 1'b0;
            count_reg   <= '0;
            total_reg   <= '0;
            orig_reg    <= '0;
            mod_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= cmd.step;
            done_reg    <= cmd.finish;
            if (cmd.load)
            begin
                idx_reg   <= '0;
                sum_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    idx_reg <= idx_reg + XW'(1);
                end
                if (pending_reg)
                begin
                    if (rd_pos <= pos_reg)
                    begin
                        sum_reg <= sum_reg + SW'(rd_chg);
                    end
                    if (rd_pos == pos_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end
            if (do_write)
            begin
                count_reg <= count_reg + NW'(1);
            end
            total_reg <= total_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ioat_pkg::CFG_ORIGINAL_LENGTH: orig_reg <= cfg_data;
                    ioat_pkg::CFG_MODIFIED_LENGTH: mod_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign done          = done_reg;
    assign offset_adjust = offset_reg;
    assign insert_ok     = ok_reg;
    assign duplicate     = dup_reg;
    assign table_full    = full_reg;
    assign reconcile_ok  = recon_reg;

endmodule

`default_nettype wire

/* hw/rtl/indel_offset_accounting_table.sv */
// Channel    Handshake               Payload
// command    start / busy            op, position, size_change
// result     done (one-cycle strobe) offset_adjust, insert_ok, duplicate,
//                                    table_full, reconcile_ok
// config     cfg_we                  cfg_index, cfg_data
//
// A transaction reads each of the N stored entries from the entry memory in
// turn, waits out the registered memory read, applies the last update and
// registers the result; an empty table skips the scan and the read latency.
// Reset clears the entry count, the running total and both length registers.
// The result strobe cannot be held off; busy stays low from the done cycle on.
`default_nettype none

module indel_offset_accounting_table (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic                              op,
    input  wire logic [31:0]                       position,
    input  wire logic signed [ioat_pkg::CHG_W-1:0] size_change,
    output      logic                              done,
    output      logic signed [ioat_pkg::SUM_W-1:0] offset_adjust,
    output      logic                              insert_ok,
    output      logic                              duplicate,
    output      logic                              table_full,
    output      logic                              reconcile_ok,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [ioat_pkg::CFG_W-1:0]        cfg_data
);

    ioat_pkg::cmd_t    cmd;
    ioat_pkg::status_t status;

    ioat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    ioat_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .position     (position),
        .size_change  (size_change),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .offset_adjust(offset_adjust),
        .insert_ok    (insert_ok),
        .duplicate    (duplicate),
        .table_full   (table_full),
        .reconcile_ok (reconcile_ok)
    );

endmodule

`default_nettype wire

/* dv/indel_offset_accounting_table_tb.sv */
`default_nettype none

module indel_offset_accounting_table_tb;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = ioat_pkg::CAPACITY + 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 160;

    typedef struct packed {
        logic signed [ioat_pkg::SUM_W-1:0] offset_adjust;
        logic                              insert_ok;
        logic                              duplicate;
        logic                              table_full;
        logic                              reconcile_ok;
    } edit_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              op = ioat_pkg::OP_QUERY;
    logic [31:0]                       position = '0;
    logic signed [ioat_pkg::CHG_W-1:0] size_change = '0;
    logic                              done;
    logic signed [ioat_pkg::SUM_W-1:0] offset_adjust;
    logic                              insert_ok;
    logic                              duplicate;
    logic                              table_full;
    logic                              reconcile_ok;
    logic                              cfg_we = 1'b0;
    logic                              cfg_index = ioat_pkg::CFG_ORIGINAL_LENGTH;
    logic [ioat_pkg::CFG_W-1:0]        cfg_data = '0;

    // Shadow copy of the edit table and the length registers.
    logic [31:0]                       edit_pos [ioat_pkg::CAPACITY];
    logic signed [ioat_pkg::CHG_W-1:0] edit_chg [ioat_pkg::CAPACITY];
    logic                              edit_used [ioat_pkg::CAPACITY];
    int                                edit_count;
    logic signed [ioat_pkg::SUM_W-1:0] edit_total;
    logic [ioat_pkg::CFG_W-1:0]        orig_len;
    logic [ioat_pkg::CFG_W-1:0]        mod_len;

    edit_result_t pending_results[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    logic         no_gaps = 1'b0;

    indel_offset_accounting_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .position     (position),
        .size_change  (size_change),
        .done         (done),
        .offset_adjust(offset_adjust),
        .insert_ok    (insert_ok),
        .duplicate    (duplicate),
        .table_full   (table_full),
        .reconcile_ok (reconcile_ok),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic edit_result_t apply_edit(logic op_v, logic [31:0] pos_v,
                                                logic signed [ioat_pkg::CHG_W-1:0] chg_v);
        edit_result_t                      r;
        logic signed [ioat_pkg::SUM_W-1:0] acc;
        logic                              found;
        int                                free_idx;
        logic signed [63:0]                total_ext;
        logic [63:0]                       lhs;
        acc = '0;
        found = 1'b0;
        free_idx = -1;
        for (int i = 0; i < ioat_pkg::CAPACITY; i++)
        begin
            if (edit_used[i])
            begin
                if (edit_pos[i] <= pos_v)
                    acc = acc + edit_chg[i];
                if (edit_pos[i] == pos_v)
                    found = 1'b1;
            end
            else if (free_idx < 0)
            begin
                free_idx = i;
            end
        end
        r = '0;
        r.offset_adjust = acc;
        if (op_v == ioat_pkg::OP_INSERT)
        begin
            if (found)
                r.duplicate = 1'b1;
            else if (edit_count >= ioat_pkg::CAPACITY || free_idx < 0)
                r.table_full = 1'b1;
            else
            begin
                edit_pos[free_idx] = pos_v;
                edit_chg[free_idx] = chg_v;
                edit_used[free_idx] = 1'b1;
                edit_count++;
                edit_total = edit_total + chg_v;
                r.insert_ok = 1'b1;
            end
        end
        total_ext = edit_total;
        lhs = {32'b0, orig_len} + total_ext;
        r.reconcile_ok = (lhs == {32'b0, mod_len});
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_gaps || roll < 40)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    task automatic send_item(logic op_v, logic [31:0] pos_v,
                             logic signed [ioat_pkg::CHG_W-1:0] chg_v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= op_v;
        position <= pos_v;
        size_change <= chg_v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_edit(op_v, pos_v, chg_v));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_lengths(logic [ioat_pkg::CFG_W-1:0] orig_v,
                                 logic [ioat_pkg::CFG_W-1:0] mod_v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= ioat_pkg::CFG_ORIGINAL_LENGTH;
        cfg_data <= orig_v;
        @(posedge clk);
        cfg_index <= ioat_pkg::CFG_MODIFIED_LENGTH;
        cfg_data <= mod_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        orig_len = orig_v;
        mod_len = mod_v;
    endtask

    // Chooses lengths that balance against the current total when that is possible.
    task automatic write_balanced_lengths();
        longint t;
        longint lo;
        longint hi;
        longint o;
        t = edit_total;
        lo = (t < 0) ? -t : 0;
        hi = (t > 0) ? 64'hFFFF_FFFF - t : 64'hFFFF_FFFF;
        if (lo <= hi)
        begin
            o = lo + longint'($urandom_range(32'(hi - lo)));
            write_lengths(32'(o), 32'(o + t));
        end
        else
        begin
            write_lengths($urandom, $urandom);
        end
    endtask

    function automatic logic [31:0] stored_position();
        return edit_pos[$urandom_range(edit_count - 1)];
    endfunction

    function automatic logic [31:0] fresh_position();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return $urandom;
        else if (roll < 90)
            return $urandom_range(4095);
        else
            return (roll < 95) ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic signed [ioat_pkg::CHG_W-1:0] random_change();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return $signed(32'($urandom_range(4096))) - 32'sd2048;
        else if (roll < 85)
            return $urandom;
        else
        begin
            case ($urandom_range(3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
    endfunction

    task automatic send_random_item();
        int          roll;
        int          insert_pct;
        logic [31:0] pos_v;
        roll = $urandom_range(99);
        insert_pct = (edit_count < ioat_pkg::CAPACITY) ? 12 : 35;
        if (roll < insert_pct)
        begin
            if (edit_count > 0 && $urandom_range(99) < 35)
                pos_v = stored_position();
            else
                pos_v = fresh_position();
            send_item(ioat_pkg::OP_INSERT, pos_v, random_change());
        end
        else
        begin
            roll = $urandom_range(99);
            if (edit_count > 0 && roll < 30)
                pos_v = stored_position() + 32'($signed($urandom_range(2)) - 1);
            else if (roll < 45)
                pos_v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            else if (roll < 70)
                pos_v = $urandom_range(4095);
            else
                pos_v = $urandom;
            send_item(ioat_pkg::OP_QUERY, pos_v, $urandom);
        end
    endtask

    task automatic test_empty_table();
        send_item(ioat_pkg::OP_QUERY, 32'h0, 32'sd5);
        send_item(ioat_pkg::OP_QUERY, 32'hFFFF_FFFF, -32'sd5);
    endtask

    task automatic test_length_extremes();
        write_lengths(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(ioat_pkg::OP_QUERY, 32'h10, 32'sd0);
        write_lengths(32'h0, 32'hFFFF_FFFF);
        send_item(ioat_pkg::OP_QUERY, 32'h10, 32'sd0);
        write_lengths(32'hFFFF_FFFF, 32'h0);
        send_item(ioat_pkg::OP_QUERY, 32'h10, 32'sd0);
        write_lengths(32'h0, 32'h0);
    endtask

    task automatic test_directed_edits();
        send_item(ioat_pkg::OP_INSERT, 32'h0, 32'sh7FFF_FFFF);
        send_item(ioat_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000);
        send_item(ioat_pkg::OP_INSERT, 32'd100, -32'sd1);
        send_item(ioat_pkg::OP_INSERT, 32'd100, 32'sd5);
        send_item(ioat_pkg::OP_INSERT, 32'h0, 32'sd9);
        send_item(ioat_pkg::OP_INSERT, 32'd50, 32'sd0);
        send_item(ioat_pkg::OP_QUERY, 32'h0, 32'sd0);
        send_item(ioat_pkg::OP_QUERY, 32'd99, 32'sd0);
        send_item(ioat_pkg::OP_QUERY, 32'd100, 32'sd0);
        send_item(ioat_pkg::OP_QUERY, 32'd101, 32'sd0);
        send_item(ioat_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'sd0);
        send_item(ioat_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'sd0);
        write_balanced_lengths();
        send_item(ioat_pkg::OP_QUERY, 32'd200, 32'sd0);
        send_item(ioat_pkg::OP_INSERT, 32'd300, 32'sd1);
    endtask

    task automatic test_random_edits();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: write_lengths($urandom, $urandom);
                2: write_lengths($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0,
                                 $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
                default: write_balanced_lengths();
            endcase
            no_gaps = (p % 5 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_full_table();
        write_balanced_lengths();
        while (edit_count < ioat_pkg::CAPACITY)
            send_item(ioat_pkg::OP_INSERT, $urandom, random_change());
        send_item(ioat_pkg::OP_INSERT, $urandom, random_change());
        send_item(ioat_pkg::OP_INSERT, stored_position(), random_change());
        send_item(ioat_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'sd0);
        send_item(ioat_pkg::OP_INSERT, 32'h0, random_change());
    endtask

    task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        edit_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual offset %0h",
                         $time, offset_adjust);
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("offset_adjust", 64'(want.offset_adjust), 64'(offset_adjust));
                report_field("insert_ok", 64'(want.insert_ok), 64'(insert_ok));
                report_field("duplicate", 64'(want.duplicate), 64'(duplicate));
                report_field("table_full", 64'(want.table_full), 64'(table_full));
                report_field("reconcile_ok", 64'(want.reconcile_ok), 64'(reconcile_ok));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < ioat_pkg::CAPACITY; i++)
            edit_used[i] = 1'b0;
        edit_count = 0;
        edit_total = '0;
        orig_len = '0;
        mod_len = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_length_extremes();
        test_directed_edits();
        test_random_edits();
        test_full_table();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/ioat_pkg.sv
hw/rtl/ioat_ram.sv
hw/rtl/ioat_ctrl.sv
hw/rtl/ioat_dp.sv
hw/rtl/indel_offset_accounting_table.sv
dv/indel_offset_accounting_table_tb.sv
